// ===== rtl/sbdft_pkg.sv =====
// Shared types, constants and coefficient tables for the single-bin DFT phasor extractor.
`timescale 1ns / 1ps
`default_nettype none

package sbdft_pkg;

    localparam int SMP_W     = 12;
    localparam int COEF_W    = 17;
    localparam int PROD_W    = SMP_W + 1 + COEF_W;
    localparam int ACC_W     = 38;
    localparam int PHASE_W   = 4;
    localparam int POINTS_PER_PERIOD = 12;
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(POINTS_PER_PERIOD - 1);

    // config port
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CYCLES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CYCLES  = 1'b1;
    localparam logic [6:0] WINDOW_RESET = 7'd32;
    localparam logic [5:0] BLANK_RESET  = 6'd4;

    // rotation by +15 degrees, unsigned Q0.15
    localparam int FRAC_W  = 15;
    localparam int ROT_W   = 15;
    localparam logic [ROT_W-1:0] ROT_COS = 15'd31651;
    localparam logic [ROT_W-1:0] ROT_SIN = 15'd8481;
    localparam int LO_W    = 19;
    localparam int HI_W    = ACC_W - LO_W;
    localparam int LO_PW   = LO_W + ROT_W;
    localparam int HI_PW   = HI_W + ROT_W + 1;
    localparam int FULL_W  = ACC_W + ROT_W + 1;
    localparam int SUM_W   = FULL_W + 1;
    localparam int SH_W    = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

    typedef struct packed {
        logic                vld;
        logic [PHASE_W-1:0]  k;
        logic                counts;
        logic                win_end;
    } t_stage_ctl;

    function automatic logic signed [COEF_W-1:0] cos_coef(input logic [PHASE_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        unique case (k)
            4'd0:    c = 17'sd32768;
            4'd1:    c = 17'sd28378;
            4'd2:    c = 17'sd16384;
            4'd3:    c = 17'sd0;
            4'd4:    c = -17'sd16384;
            4'd5:    c = -17'sd28378;
            4'd6:    c = -17'sd32768;
            4'd7:    c = -17'sd28378;
            4'd8:    c = -17'sd16384;
            4'd9:    c = 17'sd0;
            4'd10:   c = 17'sd16384;
            4'd11:   c = 17'sd28378;
            default: c = 17'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] sin_coef(input logic [PHASE_W-1:0] k);
        logic signed [COEF_W-1:0] s;
        unique case (k)
            4'd0:    s = 17'sd0;
            4'd1:    s = 17'sd16384;
            4'd2:    s = 17'sd28378;
            4'd3:    s = 17'sd32768;
            4'd4:    s = 17'sd28378;
            4'd5:    s = 17'sd16384;
            4'd6:    s = 17'sd0;
            4'd7:    s = -17'sd16384;
            4'd8:    s = -17'sd28378;
            4'd9:    s = -17'sd32768;
            4'd10:   s = -17'sd28378;
            4'd11:   s = -17'sd16384;
            default: s = 17'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sbdft_ctrl.sv =====
// Sample phase and period counters, blanking and end-of-window decode.
`timescale 1ns / 1ps
`default_nettype none

module sbdft_ctrl #(
    parameter int MAX_WINDOW_PERIODS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [6:0]              i_window_cycles,
    input  logic [5:0]              i_blank_cycles,
    output sbdft_pkg::t_stage_ctl   o_ctl,
    output logic                    o_win_end_next
);
    import sbdft_pkg::*;

    localparam int PCW = $clog2(MAX_WINDOW_PERIODS + 1);
    localparam int CW  = ((PCW > 7) ? PCW : 7) + 1;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PCW-1:0]     r_period, n_period;
    t_stage_ctl         r_ctl, n_ctl;

    logic [CW-1:0]      win_eff;
    logic [CW-1:0]      period_ext;
    logic [PHASE_W-1:0] k;
    logic               last_phase;
    logic               win_end;

    always_comb begin
        win_eff = CW'(i_window_cycles);
        if (win_eff == '0) begin
            win_eff = CW'(1);
        end else if (win_eff > CW'(MAX_WINDOW_PERIODS)) begin
            win_eff = CW'(MAX_WINDOW_PERIODS);
        end
        period_ext = CW'(r_period);
        k          = (r_phase >= LAST_PHASE) ? LAST_PHASE : r_phase;
        last_phase = (k == LAST_PHASE);
        win_end    = last_phase && ((period_ext + CW'(1)) >= win_eff);

        n_phase  = r_phase;
        n_period = r_period;
        n_ctl    = '0;
        if (i_accept) begin
            n_phase = last_phase ? '0 : k + PHASE_W'(1);
            if (win_end) begin
                n_period = '0;
            end else if (last_phase) begin
                n_period = PCW'(period_ext + CW'(1));
            end
            n_ctl.vld     = 1'b1;
            n_ctl.k       = k;
            n_ctl.counts  = period_ext >= CW'(i_blank_cycles);
            n_ctl.win_end = win_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_period <= '0;
            r_ctl    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_period <= n_period;
            r_ctl    <= n_ctl;
        end
    end

    assign o_ctl          = r_ctl;
    assign o_win_end_next = win_end;

endmodule

`default_nettype wire

// ===== rtl/sbdft_acc.sv =====
// One channel: coefficient multiply and running re/im sums, snapshot at end of window.
`timescale 1ns / 1ps
`default_nettype none

module sbdft_acc (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [sbdft_pkg::SMP_W-1:0]           i_sample,
    input  sbdft_pkg::t_stage_ctl                 i_ctl,
    output logic                                  o_snap_vld,
    output logic signed [sbdft_pkg::ACC_W-1:0]    o_snap_re,
    output logic signed [sbdft_pkg::ACC_W-1:0]    o_snap_im
);
    import sbdft_pkg::*;

    logic [SMP_W-1:0]         r_smp;
    logic signed [PROD_W-1:0] r_prod_re, r_prod_im, n_prod_re, n_prod_im;
    logic                     r_p_vld, r_p_end;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic signed [ACC_W-1:0]  sum_re, sum_im;
    logic                     r_snap_vld;
    logic signed [ACC_W-1:0]  r_snap_re, r_snap_im;
    logic signed [SMP_W:0]    smp_s;

    always_comb begin
        smp_s     = $signed({1'b0, r_smp});
        n_prod_re = '0;
        n_prod_im = '0;
        if (i_ctl.counts) begin
            n_prod_re = PROD_W'(smp_s) * PROD_W'(cos_coef(i_ctl.k));
            n_prod_im = PROD_W'(smp_s) * PROD_W'(sin_coef(i_ctl.k));
        end
        sum_re = r_acc_re + ACC_W'(r_prod_re);
        sum_im = r_acc_im + ACC_W'(r_prod_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld    <= 1'b0;
            r_p_end    <= 1'b0;
            r_acc_re   <= '0;
            r_acc_im   <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            r_p_vld    <= i_ctl.vld;
            r_p_end    <= i_ctl.vld && i_ctl.win_end;
            r_snap_vld <= r_p_vld && r_p_end;
            if (r_p_vld) begin
                if (r_p_end) begin
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end else begin
                    r_acc_re <= sum_re;
                    r_acc_im <= sum_im;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_smp <= i_sample;
        end
        if (i_ctl.vld) begin
            r_prod_re <= n_prod_re;
            r_prod_im <= n_prod_im;
        end
        if (r_p_vld && r_p_end) begin
            r_snap_re <= sum_re;
            r_snap_im <= sum_im;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap_re  = r_snap_re;
    assign o_snap_im  = r_snap_im;

endmodule

`default_nettype wire

// ===== rtl/sbdft_rot.sv =====
// One channel: +15 degree phasor rotation in split partial products, rounding, saturation.
`timescale 1ns / 1ps
`default_nettype none

module sbdft_rot (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic signed [sbdft_pkg::ACC_W-1:0]    i_x,
    input  logic signed [sbdft_pkg::ACC_W-1:0]    i_y,
    output logic                                  o_vld,
    output logic signed [sbdft_pkg::ACC_W-1:0]    o_re,
    output logic signed [sbdft_pkg::ACC_W-1:0]    o_im
);
    import sbdft_pkg::*;

    localparam logic signed [ACC_W-1:0] OUT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] OUT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // product order: x*cos, y*sin, x*sin, y*cos
    logic signed [ACC_W-1:0]  op_x [4];
    logic [ROT_W-1:0]         op_c [4];
    logic [LO_PW-1:0]         n_lo [4];
    logic signed [HI_PW-1:0]  n_hi [4];
    logic signed [FULL_W-1:0] n_full [4];

    logic [LO_PW-1:0]         r_lo [4];
    logic signed [HI_PW-1:0]  r_hi [4];
    logic signed [FULL_W-1:0] r_full [4];
    logic signed [SH_W-1:0]   r_re, r_im;
    logic                     r_v1, r_v2, r_v3;

    logic signed [SUM_W-1:0]  sum_re, sum_im;

    always_comb begin
        op_x[0] = i_x; op_c[0] = ROT_COS;
        op_x[1] = i_y; op_c[1] = ROT_SIN;
        op_x[2] = i_x; op_c[2] = ROT_SIN;
        op_x[3] = i_y; op_c[3] = ROT_COS;
        for (int i = 0; i < 4; i++) begin
            n_lo[i] = LO_PW'(op_x[i][LO_W-1:0]) * LO_PW'(op_c[i]);
            n_hi[i] = HI_PW'($signed(op_x[i][ACC_W-1:LO_W])) * HI_PW'($signed({1'b0, op_c[i]}));
            n_full[i] = (FULL_W'(r_hi[i]) <<< LO_W) + FULL_W'($signed({1'b0, r_lo[i]}));
        end
        sum_re = SUM_W'(r_full[0]) - SUM_W'(r_full[1]) + ROUND_HALF;
        sum_im = SUM_W'(r_full[2]) + SUM_W'(r_full[3]) + ROUND_HALF;
    end

    function automatic logic signed [ACC_W-1:0] sat_out(input logic signed [SH_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if ((v[SH_W-1:ACC_W-1] == '0) || (v[SH_W-1:ACC_W-1] == '1)) begin
            r = v[ACC_W-1:0];
        end else begin
            r = v[SH_W-1] ? OUT_MIN : OUT_MAX;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (r_v1) begin
            r_full <= n_full;
        end
        if (r_v2) begin
            r_re <= $signed(sum_re[SUM_W-1:FRAC_W]);
            r_im <= $signed(sum_im[SUM_W-1:FRAC_W]);
        end
    end

    assign o_vld = r_v3;
    assign o_re  = sat_out(r_re);
    assign o_im  = sat_out(r_im);

endmodule

`default_nettype wire

// ===== rtl/single_bin_dft_phasor_extractor.sv =====
// Top level: single-bin 12-point DFT phasor extractor for current and voltage.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_current_sample, i_voltage_sample
//  result    out        o_valid / i_stall    o_current_re/im, o_voltage_re/im
//  config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One item per cycle is taken while o_stall is low; a window's result runs
// through the counter, multiply, accumulate and three rotation stages.
// Synchronous active-low reset clears counters, sums and valids; config goes to
// window 32, blank 4. o_stall rises only for a window's last item while the
// previous window's result has not yet been read from the output register.
`timescale 1ns / 1ps
`default_nettype none

module single_bin_dft_phasor_extractor #(
    parameter int MAX_WINDOW_PERIODS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [sbdft_pkg::SMP_W-1:0]            i_current_sample,
    input  logic [sbdft_pkg::SMP_W-1:0]            i_voltage_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [sbdft_pkg::ACC_W-1:0]     o_current_re,
    output logic signed [sbdft_pkg::ACC_W-1:0]     o_current_im,
    output logic signed [sbdft_pkg::ACC_W-1:0]     o_voltage_re,
    output logic signed [sbdft_pkg::ACC_W-1:0]     o_voltage_im,
    input  logic                                   i_cfg_wr_en,
    input  logic [sbdft_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sbdft_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import sbdft_pkg::*;

    logic [6:0]  r_window_cycles;
    logic [5:0]  r_blank_cycles;
    logic        r_pend, n_pend;
    logic        r_o_valid, n_o_valid;
    logic signed [ACC_W-1:0] r_cur_re, r_cur_im, r_vol_re, r_vol_im;

    logic        in_accept;
    logic        out_accept;
    logic        win_end_next;
    t_stage_ctl  stage_ctl;

    logic                    cur_snap_vld, vol_snap_vld;
    logic signed [ACC_W-1:0] cur_snap_re, cur_snap_im, vol_snap_re, vol_snap_im;
    logic                    cur_rot_vld, vol_rot_vld;
    logic signed [ACC_W-1:0] cur_rot_re, cur_rot_im, vol_rot_re, vol_rot_im;

    assign o_stall    = r_pend && win_end_next;
    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_o_valid && !i_stall;

    sbdft_ctrl #(
        .MAX_WINDOW_PERIODS(MAX_WINDOW_PERIODS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_window_cycles (r_window_cycles),
        .i_blank_cycles  (r_blank_cycles),
        .o_ctl           (stage_ctl),
        .o_win_end_next  (win_end_next)
    );

    sbdft_acc u_acc_cur (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_sample   (i_current_sample),
        .i_ctl      (stage_ctl),
        .o_snap_vld (cur_snap_vld),
        .o_snap_re  (cur_snap_re),
        .o_snap_im  (cur_snap_im)
    );

    sbdft_acc u_acc_vol (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_sample   (i_voltage_sample),
        .i_ctl      (stage_ctl),
        .o_snap_vld (vol_snap_vld),
        .o_snap_re  (vol_snap_re),
        .o_snap_im  (vol_snap_im)
    );

    sbdft_rot u_rot_cur (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cur_snap_vld),
        .i_x     (cur_snap_re),
        .i_y     (cur_snap_im),
        .o_vld   (cur_rot_vld),
        .o_re    (cur_rot_re),
        .o_im    (cur_rot_im)
    );

    sbdft_rot u_rot_vol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vol_snap_vld),
        .i_x     (vol_snap_re),
        .i_y     (vol_snap_im),
        .o_vld   (vol_rot_vld),
        .o_re    (vol_rot_re),
        .o_im    (vol_rot_im)
    );

    always_comb begin
        n_pend = r_pend;
        if (in_accept && win_end_next) begin
            n_pend = 1'b1;
        end else if (out_accept) begin
            n_pend = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (cur_rot_vld) begin
            n_o_valid = 1'b1;
        end else if (out_accept) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_cycles <= WINDOW_RESET;
            r_blank_cycles  <= BLANK_RESET;
            r_pend          <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_CYCLES: r_window_cycles <= i_cfg_data[6:0];
                    CFG_BLANK_CYCLES:  r_blank_cycles  <= i_cfg_data[5:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cur_rot_vld) begin
            r_cur_re <= cur_rot_re;
            r_cur_im <= cur_rot_im;
            r_vol_re <= vol_rot_re;
            r_vol_im <= vol_rot_im;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_current_re = r_cur_re;
    assign o_current_im = r_cur_im;
    assign o_voltage_re = r_vol_re;
    assign o_voltage_im = r_vol_im;

    // a result is only ever shown while its window is marked pending
    a_out_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_pend)
        else $error("result shown without pending window");

    // the rotation stage never lands on an unread result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_rot_vld |-> !r_o_valid)
        else $error("result register overrun");

    // both channels finish in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cur_snap_vld == vol_snap_vld) && (cur_rot_vld == vol_rot_vld))
        else $error("channel pipelines out of step");

    // a window only ends on the last sample phase
    a_end_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_ctl.vld && stage_ctl.win_end) |-> (stage_ctl.k == LAST_PHASE))
        else $error("window end off the last phase");

    // a snapshot leaves the sums only for a window still pending
    a_snap_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_snap_vld |-> r_pend)
        else $error("snapshot without pending window");

endmodule

`default_nettype wire
